// ===== hdl/urlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared payload types, character constants and the small helper functions
// used by the decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  // Characters with a special meaning in the encoded stream.
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;

  // Result queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = 3;

  // Escape sequence tracking.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Result transfer payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_escape;
  } out_t;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO)  && (c <= CH_NINE))  ||
           ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
           ((c >= CH_UP_A)  && (c <= CH_UP_F));
  endfunction

  // Nibble value of a hex digit; zero for anything else.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      v = c - CH_ZERO;
    end else if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) begin
      v = c - CH_LOW_A + 8'd10;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
      v = c - CH_UP_A + 8'd10;
    end
    return v[3:0];
  endfunction

  // Ordinary character: a plus becomes a space.
  function automatic logic [7:0] plain(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

// ===== hdl/url_percent_decoder_top.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder for URL-encoded strings, one encoded byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one encoded byte per
//   transfer together with a last-of-string flag. Result channel
//   (out_valid/out_ready/out_data) carries decoded bytes, the last flag and
//   a bad_escape flag; a bad escape yields a single zero byte marked last.
//   An input transfer yields zero, one or two results. The decode logic sits
//   between the input handshake and a four-entry result queue, so each result
//   is written into the queue and presented from there.
//   Throughput is one input byte per cycle; the only limit is the queue,
//   which must have room for two results (at most two entries held) before
//   an input transfer is taken. A percent sign followed only by the last
//   byte of its string gives two results from one input and so can fill
//   the queue.
//   Reset (rst_n low, synchronous) empties the queue and clears any pending
//   escape or discard state. When the receiver stalls, results wait in the
//   queue and in_ready drops once it holds three or more entries.
// ----------------------------------------------------------------------------
module url_percent_decoder_top
  import urlpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Decoder state.
  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       discard_r, discard_nxt;

  // Result queue.
  out_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  // Per-transfer decode results.
  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] n_push;
  out_t       res0;
  out_t       res1;

  assign in_ready  = (count_r <= QCW'(QDEPTH - 2));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_xfer  = out_valid && out_ready;
  assign out_data  = q_r[rd_ptr_r];

  // Decode one input byte against the escape state.
  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    discard_nxt = discard_r;
    n_push      = 2'd0;
    res0        = '{out_byte: plain(in_data.in_byte), out_last: in_data.in_last,
                    bad_escape: 1'b0};
    res1        = '{out_byte: plain(in_data.in_byte), out_last: 1'b1,
                    bad_escape: 1'b0};
    if (in_xfer) begin
      priority if (discard_r) begin
        // Drop bytes until the end of the failed string.
        if (in_data.in_last) begin
          discard_nxt = 1'b0;
        end
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_PCT: begin
            if (in_data.in_last) begin
              // Percent with only one byte after it: pass both through.
              phase_nxt = PH_IDLE;
              res0      = '{out_byte: CH_PERCENT, out_last: 1'b0, bad_escape: 1'b0};
              n_push    = 2'd2;
            end else if (!is_hex(in_data.in_byte)) begin
              phase_nxt   = PH_IDLE;
              discard_nxt = 1'b1;
              res0        = '{out_byte: 8'd0, out_last: 1'b1, bad_escape: 1'b1};
              n_push      = 2'd1;
            end else begin
              held_nxt  = in_data.in_byte;
              phase_nxt = PH_DIGIT;
            end
          end
          PH_DIGIT: begin
            phase_nxt = PH_IDLE;
            n_push    = 2'd1;
            if (!is_hex(in_data.in_byte)) begin
              discard_nxt = !in_data.in_last;
              res0        = '{out_byte: 8'd0, out_last: 1'b1, bad_escape: 1'b1};
            end else begin
              res0.out_byte = {hex_value(held_r), hex_value(in_data.in_byte)};
            end
          end
          default: begin
            // Idle: a percent not at the end opens an escape.
            if ((in_data.in_byte == CH_PERCENT) && !in_data.in_last) begin
              phase_nxt = PH_PCT;
            end else begin
              phase_nxt = PH_IDLE;
              n_push    = 2'd1;
            end
          end
        endcase
      end
    end
  end

  // Queue pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(n_push);
    rd_ptr_nxt = rd_ptr_r + QAW'(out_xfer);
    count_nxt  = count_r + QCW'(n_push) - QCW'(out_xfer);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      held_r    <= 8'd0;
      discard_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      discard_r <= discard_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
    end
  end

  // Queue storage; the second result goes into the entry after the first.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + QAW'(1)] <= res1;
    end
  end

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("result queue overflow");

  // An error result always closes the string and carries a zero byte.
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_escape) |-> (out_data.out_last && out_data.out_byte == 8'd0))
    else $error("malformed error result");

  // While dropping a string no escape is pending.
  a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (phase_r == PH_IDLE))
    else $error("escape pending while discarding");

  // A transfer that pushes two results must have found room for both.
  a_two_room: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push == 2'd2) |=> (count_r >= QCW'(2)))
    else $error("double push lost an entry");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Feeds encoded strings through the valid/ready input channel. The strings
// are a short directed table followed by random strings built mostly from
// well-formed escapes, pluses, lone and broken percent signs and noise. A
// behavioural decoder predicts the results, save for directed rows that give
// them in full. The result channel is checked in order against the queue of
// expected characters. Idling on both sides varies from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import urlpd_pkg::*;

  // One row of the directed table. Where typed is set, the row's results are
  // written out in full; otherwise the behavioural decoder supplies them.
  typedef struct packed {
    logic [7:0] chr;
    logic       lst;
    logic       typed;
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } dir_row_t;

  localparam out_t NONE = '0;
  localparam out_t BAD  = '{8'h00, 1'b1, 1'b1};
  localparam int   NDIR = 25;

  localparam dir_row_t DIRECTED [NDIR] = '{
    '{8'h00,      1'b0, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b0}, NONE},
    '{8'hFF,      1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NONE},
    '{CH_PLUS,    1'b1, 1'b1, 2'd1, '{CH_SPACE, 1'b1, 1'b0}, NONE},
    // Percent sign as the last character of a string.
    '{CH_PERCENT, 1'b1, 1'b1, 2'd1, '{CH_PERCENT, 1'b1, 1'b0}, NONE},
    // Percent sign with only one character left after it.
    '{CH_PERCENT, 1'b0, 1'b1, 2'd0, NONE, NONE},
    '{CH_PLUS,    1'b1, 1'b1, 2'd2, '{CH_PERCENT, 1'b0, 1'b0},
                                    '{CH_SPACE, 1'b1, 1'b0}},
    // Escapes at the edges of the digit ranges.
    '{CH_PERCENT, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{CH_ZERO,    1'b0, 1'b0, 2'd0, NONE, NONE},
    '{CH_NINE,    1'b0, 1'b1, 2'd1, '{8'h09, 1'b0, 1'b0}, NONE},
    '{CH_PERCENT, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{CH_LOW_F,   1'b0, 1'b0, 2'd0, NONE, NONE},
    '{CH_UP_F,    1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NONE},
    // Bad first digit mid-string: the rest of the string is dropped.
    '{CH_PERCENT, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h67,      1'b0, 1'b1, 2'd1, BAD, NONE},
    '{CH_PERCENT, 1'b0, 1'b1, 2'd0, NONE, NONE},
    '{8'h78,      1'b1, 1'b1, 2'd0, NONE, NONE},
    // Bad second digit on the last character: nothing left to drop.
    '{CH_PERCENT, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h34,      1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h3A,      1'b1, 1'b1, 2'd1, BAD, NONE},
    // Bad second digit mid-string, then a dropped last character.
    '{CH_PERCENT, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{CH_UP_A,    1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h40,      1'b0, 1'b1, 2'd1, BAD, NONE},
    '{CH_PLUS,    1'b1, 1'b1, 2'd0, NONE, NONE},
    // Two percent signs ending a string.
    '{CH_PERCENT, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{CH_PERCENT, 1'b1, 1'b0, 2'd0, NONE, NONE}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Decoder state mirrored by the predictor.
  phase_t     esc_phase;
  logic [7:0] held_digit;
  logic       dropping;

  out_t expected_chars[$];
  in_t  stim[$];
  int   mismatches;
  int   send_idle_pct;
  int   recv_stall_pct;

  url_percent_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Upper bit flags a hex digit, the low four bits give its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      return {1'b1, 4'(c - CH_LOW_A + 8'd10)};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      return {1'b1, 4'(c - CH_UP_A + 8'd10)};
    end
    return 5'd0;
  endfunction

  // Behavioural decoder: advances the mirrored state by one character and
  // returns the results that character causes.
  function automatic void decode_char(input in_t c, output int n,
                                      output out_t r0, output out_t r1);
    logic [4:0] hi;
    logic [4:0] lo;
    hi = hex_nibble(held_digit);
    lo = hex_nibble(c.in_byte);
    n  = 0;
    r0 = NONE;
    r1 = NONE;
    if (dropping) begin
      if (c.in_last) begin
        dropping = 1'b0;
      end
      esc_phase = PH_IDLE;
    end else if (esc_phase == PH_PCT) begin
      if (c.in_last) begin
        esc_phase = PH_IDLE;
        n  = 2;
        r0 = '{CH_PERCENT, 1'b0, 1'b0};
        r1 = '{(c.in_byte == CH_PLUS) ? CH_SPACE : c.in_byte, 1'b1, 1'b0};
      end else if (!lo[4]) begin
        esc_phase = PH_IDLE;
        dropping  = 1'b1;
        n  = 1;
        r0 = BAD;
      end else begin
        held_digit = c.in_byte;
        esc_phase  = PH_DIGIT;
      end
    end else if (esc_phase == PH_DIGIT) begin
      esc_phase = PH_IDLE;
      n = 1;
      if (!lo[4]) begin
        dropping = !c.in_last;
        r0 = BAD;
      end else begin
        r0 = '{{hi[3:0], lo[3:0]}, c.in_last, 1'b0};
      end
    end else begin
      // The unused phase value behaves as idle.
      esc_phase = PH_IDLE;
      if (c.in_byte == CH_PERCENT && !c.in_last) begin
        esc_phase = PH_PCT;
      end else begin
        n  = 1;
        r0 = '{(c.in_byte == CH_PLUS) ? CH_SPACE : c.in_byte, c.in_last, 1'b0};
      end
    end
  endfunction

  // Offers one character, holding it until the transfer, then records the
  // results it should cause. Typed results, where given, replace the
  // predicted ones.
  task automatic feed(input in_t item, input logic typed = 1'b0,
                      input int typed_n = 0, input out_t t0 = NONE,
                      input out_t t1 = NONE);
    int   n;
    out_t r0;
    out_t r1;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    decode_char(item, n, r0, r1);
    if (typed) begin
      n  = typed_n;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) expected_chars.insert(expected_chars.size(), r0);
    if (n > 1) expected_chars.insert(expected_chars.size(), r1);
  endtask

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 16) return CH_LOW_A + 8'(r - 10);
    return CH_UP_A + 8'(r - 16);
  endfunction

  // Characters next to the hex ranges, or any byte at all.
  function automatic logic [7:0] pick_nonhex();
    case ($urandom_range(0, 6))
      0:       return 8'h2F;
      1:       return 8'h3A;
      2:       return 8'h40;
      3:       return 8'h47;
      4:       return 8'h60;
      5:       return 8'h67;
      default: return 8'($urandom);
    endcase
  endfunction

  // Appends one random string to the stimulus, or now and then a single
  // noise character with a random last flag.
  task automatic queue_string();
    logic [7:0] chars[$];
    int         tokens;
    int         kind;
    if ($urandom_range(0, 9) == 0) begin
      stim.insert(stim.size(), '{8'($urandom), 1'($urandom)});
      return;
    end
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        chars.insert(chars.size(), CH_PERCENT);
        chars.insert(chars.size(), pick_hex());
        chars.insert(chars.size(), pick_hex());
      end else if (kind < 45) begin
        chars.insert(chars.size(), CH_PLUS);
      end else if (kind < 55) begin
        chars.insert(chars.size(), CH_PERCENT);
        if ($urandom_range(0, 1) == 1) chars.insert(chars.size(), pick_hex());
        chars.insert(chars.size(), pick_nonhex());
      end else if (kind < 60) begin
        chars.insert(chars.size(), CH_PERCENT);
      end else begin
        chars.insert(chars.size(), 8'($urandom));
      end
    end
    foreach (chars[i]) begin
      stim.insert(stim.size(), '{chars[i], (i == chars.size() - 1)});
    end
  endtask

  // Receiver: stalls at random at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker: each result transfer against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: result with none expected: byte %h last %b bad %b",
                 $time, out_data.out_byte, out_data.out_last,
                 out_data.bad_escape);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.out_last !== want.out_last ||
            out_data.bad_escape !== want.bad_escape) begin
          $display("%0t: expected byte %h last %b bad %b, got byte %h last %b bad %b",
                   $time, want.out_byte, want.out_last, want.bad_escape,
                   out_data.out_byte, out_data.out_last, out_data.bad_escape);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, four random phases, drain.
  initial begin : main_seq
    int guard;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    esc_phase      = PH_IDLE;
    held_digit     = 8'h00;
    dropping       = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      feed('{DIRECTED[i].chr, DIRECTED[i].lst}, DIRECTED[i].typed,
           int'(DIRECTED[i].n), DIRECTED[i].r0, DIRECTED[i].r1);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      while (stim.size() < 300) queue_string();
      while (stim.size() > 0) feed(stim.pop_front());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_chars.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               expected_chars.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
